// File: rtl/per_destination_message_queues_assert.svh
// Assertion macros shared by the message queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PER_DESTINATION_MESSAGE_QUEUES_ASSERT_SVH
`define PER_DESTINATION_MESSAGE_QUEUES_ASSERT_SVH
`ifndef SYNTHESIS
`define PDMQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdmq check failed");
`define PDMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdmq check failed");
`else
`define PDMQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PDMQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pdmq_pkg.sv
// Types and constants of the per-destination message queue block.
// No dependencies; imported by every module of the block except pdmq_ram.
package pdmq_pkg;

   localparam int unsigned MSG_W   = 64;
   localparam int unsigned DEST_W  = 4;
   localparam int unsigned OCC_W   = 5;
   localparam int unsigned DROP_W  = 32;
   localparam int unsigned LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_SEND  = 2'd0,
      CMD_RECV  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_DROP  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic [DEST_W-1:0]   dest;
      logic [MSG_W-1:0]    payload;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [MSG_W-1:0]    message_out;
      logic [OCC_W-1:0]    occupancy;
      logic [DROP_W-1:0]   drop_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fetch_needed;
   } dp_status_type;

endpackage

// File: rtl/pdmq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pdmq_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  addr,
   input  logic [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/pdmq_ctrl.sv
// Sequencer of the message queue block: idle, execute, fetch.
// Depends on pdmq_pkg.
module pdmq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output pdmq_pkg::ctrl_cmd_type  cmd,
   input  pdmq_pkg::dp_status_type sts
);
   import pdmq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      exec_ff;
   logic      fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         exec_ff  <= 1'b0;
         fetch_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
                  exec_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               exec_ff <= 1'b0;
               if (sts.fetch_needed) begin
                  state_ff <= ST_FETCH;
                  fetch_ff <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               fetch_ff <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
               exec_ff  <= 1'b0;
               fetch_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign cmd.load  = start && !busy_ff;
   assign cmd.exec  = exec_ff;
   assign cmd.fetch = fetch_ff;

endmodule

// File: rtl/pdmq_datapath.sv
// Queue pointers, drop counters, limit register, message store and result register.
// Depends on pdmq_pkg and pdmq_ram.
module pdmq_datapath #(
   parameter int unsigned NUM_QUEUES    = 16,
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned PAYLOAD_WIDTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pdmq_pkg::ctrl_cmd_type           cmd,
   output pdmq_pkg::dp_status_type          sts,
   input  pdmq_pkg::req_type                req_msg,
   input  logic                             csr_wr_en,
   input  logic [pdmq_pkg::LIMIT_W-1:0]     csr_wr_data,
   output logic                             rsp_strobe,
   output pdmq_pkg::rsp_type                rsp_msg
);
   import pdmq_pkg::*;

   localparam int unsigned QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int unsigned SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned SUM_W    = ((SLOT_W > OCC_W) ? SLOT_W : OCC_W) + 1;
   localparam int unsigned ADDR_W   = QIDX_W + SLOT_W;
   localparam int unsigned RAM_DEPTH = 1 << ADDR_W;

   localparam logic [8:0]        NumQ      = 9'(NUM_QUEUES);
   localparam logic [SUM_W-1:0]  DepthSum  = SUM_W'(QUEUE_DEPTH);
   localparam logic [SLOT_W-1:0] LastSlot  = SLOT_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0]  DepthCap  = OCC_W'((QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH);

   req_type              req_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_strobe_ff;
   logic [LIMIT_W-1:0]   limit_ff;

   logic [SLOT_W-1:0]    head_ff [NUM_QUEUES];
   logic [OCC_W-1:0]     fill_ff [NUM_QUEUES];
   logic [DROP_W-1:0]    drop_ff [NUM_QUEUES];

   logic [QIDX_W-1:0]    q;
   logic                 q_valid;
   logic [SLOT_W-1:0]    cur_head;
   logic [OCC_W-1:0]     cur_fill;
   logic [DROP_W-1:0]    cur_drop;
   logic [SLOT_W-1:0]    head_in;
   logic [OCC_W-1:0]     fill_in;
   logic [DROP_W-1:0]    drop_in;
   logic [OCC_W-1:0]     limit_eff;
   logic [SUM_W-1:0]     tail_sum;
   logic [SLOT_W-1:0]    tail_slot;
   logic [SLOT_W-1:0]    head_next;
   logic [SLOT_W-1:0]    ram_slot;
   logic                 ram_we;
   logic                 fetch;
   status_type           stat;
   logic [PAYLOAD_WIDTH-1:0] ram_rdata;

   assign q        = QIDX_W'(req_ff.dest);
   assign q_valid  = {5'b0, req_ff.dest} < NumQ;
   assign cur_head = head_ff[q];
   assign cur_fill = fill_ff[q];
   assign cur_drop = drop_ff[q];

   assign limit_eff = (limit_ff > DepthCap) ? DepthCap : limit_ff;

   // tail slot wraps once at most: head < depth, fill <= depth
   always_comb begin
      tail_sum = SUM_W'(cur_head) + SUM_W'(cur_fill);
      if (tail_sum >= DepthSum) begin
         tail_sum = tail_sum - DepthSum;
      end
   end
   assign tail_slot = SLOT_W'(tail_sum);
   assign head_next = (cur_head == LastSlot) ? '0 : cur_head + SLOT_W'(1);

   always_comb begin
      head_in  = cur_head;
      fill_in  = cur_fill;
      drop_in  = cur_drop;
      stat     = STAT_OK;
      ram_we   = 1'b0;
      ram_slot = cur_head;
      fetch    = 1'b0;
      if (q_valid) begin
         unique case (req_ff.command)
            CMD_SEND: begin
               if (cur_fill >= limit_eff) begin
                  drop_in = cur_drop + DROP_W'(1);
                  stat    = STAT_DROP;
               end else begin
                  ram_we   = cmd.exec;
                  ram_slot = tail_slot;
                  fill_in  = cur_fill + OCC_W'(1);
               end
            end
            CMD_RECV: begin
               if (cur_fill == '0) begin
                  stat = STAT_EMPTY;
               end else begin
                  fetch   = 1'b1;
                  head_in = head_next;
                  fill_in = cur_fill - OCC_W'(1);
               end
            end
            CMD_CLEAR: begin
               fill_in = '0;
               head_in = '0;
            end
            CMD_QUERY: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.status      = stat;
      rsp_in.message_out = '0;
      rsp_in.occupancy   = q_valid ? fill_in : '0;
      rsp_in.drop_count  = q_valid ? drop_in : '0;
   end

   assign sts.fetch_needed = fetch;

   pdmq_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  ({q, ram_slot}),
      .wdata (req_ff.payload[PAYLOAD_WIDTH-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
            drop_ff[i] <= '0;
         end
         limit_ff      <= LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.exec && q_valid) begin
            head_ff[q] <= head_in;
            fill_ff[q] <= fill_in;
            drop_ff[q] <= drop_in;
         end
         rsp_strobe_ff <= (cmd.exec && !fetch) || cmd.fetch;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_msg;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end else if (cmd.fetch) begin
         rsp_ff.message_out <= MSG_W'(ram_rdata);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_msg    = rsp_ff;

endmodule

// File: rtl/per_destination_message_queues.sv
// Per-destination message queues: one FIFO per destination with drop counting.
// Flow: an accepted command is loaded and run in EXEC; rsp_strobe rises once EXEC ends,
// or once FETCH ends for a receive that returns a message (the store's registered read
// port needs the FETCH state). A new command waits for busy to drop. Results cannot be stalled.
// Reset: synchronous; clears all pointers, fills and drop counters, limit returns to 16.
// Depends on pdmq_pkg, pdmq_ctrl, pdmq_datapath, pdmq_ram and the assert macro header.
`include "per_destination_message_queues_assert.svh"

module per_destination_message_queues #(
   parameter int unsigned NUM_QUEUES    = 16,
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned PAYLOAD_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // command transfer: taken when start is high and busy is low
   input  logic                          start,
   output logic                          busy,
   input  pdmq_pkg::req_type             req_msg,
   // result transfer: valid for the single cycle rsp_strobe is high
   output logic                          rsp_strobe,
   output pdmq_pkg::rsp_type             rsp_msg,
   // queue limit register, to be written by the user only while idle; no logic in the block enforces this
   input  logic                          csr_wr_en,
   input  logic [pdmq_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import pdmq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // Sequencer: IDLE -> EXEC (pointer update, store write or read issue)
   // -> FETCH only when a receive pulls a message out of the store.
   // A receive that hits passes through FETCH before the block goes idle again.
   pdmq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Datapath: per-queue head/fill/drop registers, store RAM, result register.
   pdmq_datapath #(
      .NUM_QUEUES    (NUM_QUEUES),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_msg     (req_msg),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_msg     (rsp_msg)
   );

   // An accepted command always holds the block busy for the next cycle.
   `PDMQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // No result can show in the cycle right after an accept.
   `PDMQ_ASSERT_NEXT(a_accept_quiet, clock, reset, start && !busy, !rsp_strobe)
   // Every result follows a busy cycle.
   `PDMQ_ASSERT_IMPLY(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   // Empty receive reports nothing held and no message.
   `PDMQ_ASSERT_IMPLY(a_empty_clean, clock, reset,
      rsp_strobe && rsp_msg.status == STAT_EMPTY,
      rsp_msg.occupancy == '0 && rsp_msg.message_out == '0)
   // A nonzero message only comes with an ok status.
   `PDMQ_ASSERT_IMPLY(a_msg_only_ok, clock, reset,
      rsp_strobe && rsp_msg.message_out != '0, rsp_msg.status == STAT_OK)

endmodule
